// File: rtl/core/bll_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the bracket language lexer.
package bll_pkg;

    localparam int POS_W     = 16;
    localparam int NUM_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CHAR_W    = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRK  = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LBRC  = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRC  = 8'h7D;

    typedef enum logic [3:0] {
        K_PLUS   = 4'd0,
        K_MINUS  = 4'd1,
        K_LEFT   = 4'd2,
        K_RIGHT  = 4'd3,
        K_LOOP_O = 4'd4,
        K_LOOP_C = 4'd5,
        K_DOT    = 4'd6,
        K_COMMA  = 4'd7,
        K_BRC_O  = 4'd8,
        K_BRC_C  = 4'd9,
        K_SEMI   = 4'd10,
        K_END    = 4'd11,
        K_NUM    = 4'd12,
        K_IDC    = 4'd13,
        K_IDE    = 4'd14,
        K_ERR    = 4'd15
    } kind_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_NUM     = 2'd1,
        MODE_IDENT   = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t             kind;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  line;
        logic [POS_W-1:0]  column;
    } tok_t;

    // One queue entry holds every token that a single byte produces.
    typedef struct packed {
        logic two;
        tok_t first;
        tok_t second;
    } entry_t;

    typedef struct packed {
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] column;
    } pos_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
    endfunction

    // Position of the next byte; a newline starts a new line, both counts saturate.
    function automatic pos_t advance(input logic [CHAR_W-1:0] c, input pos_t p);
        pos_t r;
        r = p;
        if (c == CH_NL) begin
            if (p.line != POS_MAX) begin
                r.line = p.line + POS_ONE;
            end
            r.column = POS_ONE;
        end else if (p.column != POS_MAX) begin
            r.column = p.column + POS_ONE;
        end
        return r;
    endfunction

    function automatic punct_t punct_kind(input logic [CHAR_W-1:0] c);
        punct_t r;
        r.hit  = 1'b1;
        r.kind = K_PLUS;
        case (c)
            CH_PLUS:  r.kind = K_PLUS;
            CH_MINUS: r.kind = K_MINUS;
            CH_LT:    r.kind = K_LEFT;
            CH_GT:    r.kind = K_RIGHT;
            CH_LBRK:  r.kind = K_LOOP_O;
            CH_RBRK:  r.kind = K_LOOP_C;
            CH_DOT:   r.kind = K_DOT;
            CH_COMMA: r.kind = K_COMMA;
            CH_LBRC:  r.kind = K_BRC_O;
            CH_RBRC:  r.kind = K_BRC_C;
            CH_SEMI:  r.kind = K_SEMI;
            default:  r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/bll_byte_if.sv
`timescale 1ns / 1ps
// Handshake channel carrying one source byte per word.
interface bll_byte_if
    import bll_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// File: rtl/core/bll_tok_if.sv
`timescale 1ns / 1ps
// Handshake channel carrying one token per word.
interface bll_tok_if
    import bll_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [3:0]       kind;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] column;
    logic             last;

    modport source (output valid, output kind, output value, output line,
                    output column, output last, input ready);
    modport sink   (input valid, input kind, input value, input line,
                    input column, input last, output ready);
endinterface

// File: rtl/core/bll_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, keeps the scanner state and classifies each byte into tokens.
module bll_front
    import bll_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bll_byte_if.sink         byte_ch,
    input  logic             q_ready,
    output logic             push,
    output entry_t           push_entry
);

    mode_t            mode_reg, mode_next;
    pos_t             cur_reg, cur_next;
    pos_t             start_reg, start_next;
    logic [NUM_W-1:0] accum_reg, accum_next;

    logic [CHAR_W-1:0] c;
    pos_t              adv;
    punct_t            pk;
    logic [NUM_W-1:0]  digit;
    logic              accept;

    tok_t tok_a, st;
    logic emit_a, emit_st, lead, do_start;

    assign c      = byte_ch.char_in;
    assign adv    = advance(c, cur_reg);
    assign pk     = punct_kind(c);
    assign digit  = NUM_W'(c - CH_ZERO);
    assign accept = byte_ch.valid && q_ready;

    assign byte_ch.ready = q_ready;

    always_comb
    begin
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        accum_next = accum_reg;
        tok_a      = '0;
        st         = '0;
        emit_a     = 1'b0;
        emit_st    = 1'b0;
        lead       = 1'b0;
        do_start   = 1'b0;

        case (mode_reg)
            MODE_NUM:
            begin
                if (is_digit(c))
                begin
                    accum_next = (accum_reg << 3) + (accum_reg << 1) + digit;
                    cur_next   = adv;
                end
                else
                begin
                    tok_a      = '{K_NUM, VAL_W'(accum_reg), start_reg.line, start_reg.column};
                    emit_a     = 1'b1;
                    lead       = 1'b1;
                    mode_next  = MODE_START;
                    accum_next = '0;
                    do_start   = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || (c == CH_UNDER))
                begin
                    tok_a    = '{K_IDC, VAL_W'(c), start_reg.line, start_reg.column};
                    emit_a   = 1'b1;
                    cur_next = adv;
                end
                else
                begin
                    tok_a     = '{K_IDE, '0, start_reg.line, start_reg.column};
                    emit_a    = 1'b1;
                    lead      = 1'b1;
                    mode_next = MODE_START;
                    do_start  = 1'b1;
                end
            end
            MODE_COMMENT:
            begin
                if (c == CH_NUL)
                begin
                    tok_a      = '{K_END, '0, cur_reg.line, cur_reg.column};
                    emit_a     = 1'b1;
                    mode_next  = MODE_START;
                    cur_next   = '{POS_ONE, POS_ONE};
                    start_next = '{POS_ONE, POS_ONE};
                    accum_next = '0;
                end
                else
                begin
                    if (c == CH_NL)
                    begin
                        mode_next = MODE_START;
                    end
                    cur_next = adv;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        if (do_start)
        begin
            if (pk.hit)
            begin
                st       = '{pk.kind, '0, cur_reg.line, cur_reg.column};
                emit_st  = 1'b1;
                cur_next = adv;
            end
            else if (is_space(c))
            begin
                cur_next = adv;
            end
            else if (c == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
                cur_next  = adv;
            end
            else if (c == CH_NUL)
            begin
                st         = '{K_END, '0, cur_reg.line, cur_reg.column};
                emit_st    = 1'b1;
                mode_next  = MODE_START;
                cur_next   = '{POS_ONE, POS_ONE};
                start_next = '{POS_ONE, POS_ONE};
                accum_next = '0;
            end
            else if (is_alpha(c))
            begin
                mode_next  = MODE_IDENT;
                start_next = cur_reg;
                st         = '{K_IDC, VAL_W'(c), cur_reg.line, cur_reg.column};
                emit_st    = 1'b1;
                cur_next   = adv;
            end
            else if (is_digit(c))
            begin
                mode_next  = MODE_NUM;
                start_next = cur_reg;
                accum_next = digit;
                cur_next   = adv;
            end
            else
            begin
                st         = '{K_ERR, VAL_W'(c), cur_reg.line, cur_reg.column};
                emit_st    = 1'b1;
                mode_next  = MODE_START;
                cur_next   = '{POS_ONE, POS_ONE};
                start_next = '{POS_ONE, POS_ONE};
                accum_next = '0;
            end
        end
    end

    // A closing token leads; the byte's own token, if any, follows it.
    always_comb
    begin
        push_entry.two    = lead && emit_st;
        push_entry.first  = lead ? tok_a : (emit_st ? st : tok_a);
        push_entry.second = st;
        push              = accept && (emit_a || emit_st);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            cur_reg   <= '{POS_ONE, POS_ONE};
            start_reg <= '{POS_ONE, POS_ONE};
            accum_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            accum_reg <= accum_next;
        end
    end

endmodule

// File: rtl/core/bll_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of token entries between front and back ends.
module bll_queue
    import bll_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   q_ready,
    input  logic   pop,
    output logic   q_valid,
    output entry_t q_entry
);

    entry_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    assign q_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/bll_back.sv
`timescale 1ns / 1ps
// Back end: unpacks queue entries into single tokens and holds them in the output register.
module bll_back
    import bll_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  entry_t   q_entry,
    output logic     pop,
    bll_tok_if.source tok_ch
);

    logic out_valid_reg, out_valid_next;
    logic phase_reg, phase_next;
    tok_t tok_reg, tok_next;
    logic last_reg, last_next;
    logic load;
    logic split;

    assign load  = !out_valid_reg || tok_ch.ready;
    assign split = q_entry.two && !phase_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        tok_next       = tok_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                tok_next   = (q_entry.two && phase_reg) ? q_entry.second : q_entry.first;
                last_next  = !split;
                phase_next = split;
                pop        = !split;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        last_reg <= last_next;
    end

    assign tok_ch.valid  = out_valid_reg;
    assign tok_ch.kind   = tok_reg.kind;
    assign tok_ch.value  = tok_reg.value;
    assign tok_ch.line   = tok_reg.line;
    assign tok_ch.column = tok_reg.column;
    assign tok_ch.last   = last_reg;

endmodule

// File: rtl/core/bracket_language_lexer_core.sv
`timescale 1ns / 1ps
// Bracket language lexer: source bytes in, position-tagged tokens out.
// The first token of a byte is registered in the queue and then in the output register before it is offered.
// Throughput: one byte per cycle while the queue has room; a byte that yields two tokens
// is sent as two output words, and the four-entry queue absorbs that extra word.
// Reset (rst_n low, asynchronous): scanner at line 1, column 1, start mode, queue empty.
module bracket_language_lexer_core
    import bll_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bll_byte_if.sink  byte_ch,
    bll_tok_if.source tok_ch
);

    // The front end classifies each byte in the cycle it is taken and pushes all
    // of its tokens as one queue entry.  Bytes that produce no token (whitespace,
    // comment text, digits inside a number) push nothing.  The front end only
    // stalls when the queue is full.
    logic   push;
    entry_t push_entry;
    logic   q_ready;
    logic   pop;
    logic   q_valid;
    entry_t q_entry;

    bll_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .q_ready    (q_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    // The queue decouples the two halves so that an output stall does not stop
    // the byte stream until the queue fills.
    bll_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // The back end turns each entry into one or two output words and marks the
    // final word of each byte with last.
    bll_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .tok_ch  (tok_ch)
    );

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> q_ready)
        else $error("queue pushed while full");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ch.valid && (tok_ch.kind == K_END || tok_ch.kind == K_ERR) |-> tok_ch.last)
        else $error("end or error token not marked last");

    a_lead_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_ch.valid && !tok_ch.last |-> (tok_ch.kind == K_NUM || tok_ch.kind == K_IDE))
        else $error("leading token of a pair is not a closing token");
`endif

endmodule
